// ===== hw/rtl/cycle_count_wall_clock_macros.svh =====
// Assertion macros shared by the wall clock checker.
`ifndef CYCLE_COUNT_WALL_CLOCK_MACROS_SVH
`define CYCLE_COUNT_WALL_CLOCK_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CCWC_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define CCWC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hw/rtl/ccwc_pkg.sv =====
// Shared types and constants of the cycle-count wall clock.
`default_nettype none

package ccwc_pkg;

   localparam int COUNT_W     = 64;
   localparam int SEC_W       = 32;
   localparam int NSEC_W      = 30;
   localparam int USEC_W      = 32;
   localparam int DIVISOR_W   = 16;
   localparam int REQ_TDATA_W = 128;
   localparam int RSP_TDATA_W = 64;

   // Request kinds carried on req_tuser.
   localparam logic FUNC_SAMPLE = 1'b0;
   localparam logic FUNC_SET    = 1'b1;

   localparam logic [DIVISOR_W-1:0] DIVISOR_RESET = 16'd1;

   localparam logic [NSEC_W:0]   NSEC_PER_SEC  = 31'd1000000000;
   localparam logic [USEC_W-1:0] USEC_PER_SEC  = 32'd1000000;
   localparam logic [9:0]        NSEC_PER_USEC = 10'd1000;

   // Microseconds split into seconds: usec / 1e6 == (usec >> 6) / 15625, and the
   // latter is taken as a multiply by floor(2^40 / 15625) that is at most one low.
   localparam int                RECIP_IN_LSB = 6;
   localparam int                RECIP_IN_W   = USEC_W - RECIP_IN_LSB;
   localparam int                RECIP_M_W    = 27;
   localparam logic [RECIP_M_W-1:0] RECIP_M   = 27'd70368744;
   localparam int                RECIP_SHIFT  = 40;
   localparam int                PROD1_W      = RECIP_IN_W + RECIP_M_W;
   localparam int                SEC_STEP_W   = PROD1_W - RECIP_SHIFT;
   localparam int                USEC_REM_W   = 20;

   localparam int QUEUE_DEPTH_DEFAULT = 2;

   typedef struct packed {
      logic               is_set;
      logic [COUNT_W-1:0] payload;  // elapsed count, or {nanos, seconds} for a set
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// ===== hw/rtl/cycle_count_wall_clock.sv =====
// Top level of the cycle-count wall clock.
`default_nettype none

// Wall clock of seconds and nanoseconds driven by samples of a free-running
// cycle counter. A sample request (req_tuser low) advances the clock by the
// counter difference since the previous sample divided by cycles_per_microsecond,
// written through csr_wr_en / csr_wr_data (reset value 1). A set request
// (req_tuser high) loads the time. Every request returns one response with the
// time after it and a flag that is set when the elapsed microseconds did not fit
// in 32 bits (always so with a divisor of zero). A sample leaving the command
// queue passes through a dequeue in S_IDLE, 32 steps of the radix-2 divider, a
// split of microseconds into seconds and nanoseconds (S_MUL1, S_MUL2, S_CORR,
// S_MUL3), and an update in S_APPLY that waits for the response register to be
// free. A sample whose elapsed microseconds saturate skips the divider, and a set
// goes from S_IDLE straight to S_APPLY. The front end takes up to QUEUE_DEPTH
// requests ahead of the arithmetic; a finished response waits in its own register.
module cycle_count_wall_clock #(
   parameter int QUEUE_DEPTH = ccwc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // counter_now[63:0], set_seconds[95:64], set_nanos[125:96], zero pad
   input  logic [ccwc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // seconds_now[31:0], nanos_now[61:32], quotient_saturated[62], zero pad
   output logic [ccwc_pkg::RSP_TDATA_W-1:0]    rsp_tdata,
   input  logic                                csr_wr_en,
   input  logic [ccwc_pkg::DIVISOR_W-1:0]      csr_wr_data
);
   import ccwc_pkg::*;

   queue_status_type queue_status;
   logic             push;
   cmd_type          push_cmd;
   logic             pop;
   cmd_type          pop_cmd;

   ccwc_front u_front (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .queue_status (queue_status),
      .push         (push),
      .push_cmd     (push_cmd)
   );

   ccwc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .push_cmd     (push_cmd),
      .pop          (pop),
      .pop_cmd      (pop_cmd),
      .queue_status (queue_status)
   );

   ccwc_back u_back (
      .clock        (clock),
      .reset        (reset),
      .csr_wr_en    (csr_wr_en),
      .csr_wr_data  (csr_wr_data),
      .queue_status (queue_status),
      .pop          (pop),
      .pop_cmd      (pop_cmd),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata)
   );

endmodule

`default_nettype wire

// ===== hw/rtl/ccwc_front.sv =====
// Front end: accepts requests, holds the last counter sample and queues commands.
`default_nettype none

module ccwc_front (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // counter_now[63:0], set_seconds[95:64], set_nanos[125:96], zero pad
   input  logic [ccwc_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // func
   input  logic                                req_tuser,
   input  ccwc_pkg::queue_status_type          queue_status,
   output logic                                push,
   output ccwc_pkg::cmd_type                   push_cmd
);
   import ccwc_pkg::*;

   logic [COUNT_W-1:0] prev_count_ff;
   logic [COUNT_W-1:0] prev_count_in;
   logic [COUNT_W-1:0] counter_now;
   logic [SEC_W-1:0]   set_seconds;
   logic [NSEC_W-1:0]  set_nanos;
   logic               is_set;

   assign counter_now = req_tdata[COUNT_W-1:0];
   assign set_seconds = req_tdata[COUNT_W+SEC_W-1:COUNT_W];
   assign set_nanos   = req_tdata[COUNT_W+SEC_W+NSEC_W-1:COUNT_W+SEC_W];
   assign is_set      = (req_tuser == FUNC_SET);

   assign req_tready = !queue_status.full;
   assign push       = req_tvalid && req_tready;

   always_comb begin
      push_cmd.is_set = is_set;
      if (is_set) begin
         push_cmd.payload = {{(COUNT_W-SEC_W-NSEC_W){1'b0}}, set_nanos, set_seconds};
      end else begin
         push_cmd.payload = counter_now - prev_count_ff;
      end
   end

   always_comb begin
      prev_count_in = prev_count_ff;
      if (push && !is_set) begin
         prev_count_in = counter_now;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_count_ff <= '0;
      end else begin
         prev_count_ff <= prev_count_in;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ccwc_queue.sv =====
// Short command queue between the front end and the arithmetic back end.
`default_nettype none

module ccwc_queue #(
   parameter int DEPTH = ccwc_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        push,
   input  ccwc_pkg::cmd_type           push_cmd,
   input  logic                        pop,
   output ccwc_pkg::cmd_type           pop_cmd,
   output ccwc_pkg::queue_status_type  queue_status
);
   import ccwc_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   cmd_type          entries_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign queue_status.full  = (count_ff == CNT_W'(DEPTH));
   assign queue_status.empty = (count_ff == '0);
   assign do_push = push && !queue_status.full;
   assign do_pop  = pop && !queue_status.empty;
   assign pop_cmd = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ccwc_back.sv =====
// Back end: serial divider, microsecond split, clock update and result register.
`default_nettype none

module ccwc_back (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_wr_en,
   input  logic [ccwc_pkg::DIVISOR_W-1:0]      csr_wr_data,
   input  ccwc_pkg::queue_status_type          queue_status,
   output logic                                pop,
   input  ccwc_pkg::cmd_type                   pop_cmd,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // seconds_now[31:0], nanos_now[61:32], quotient_saturated[62], zero pad
   output logic [ccwc_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import ccwc_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_DIV   = 3'd1;
   localparam logic [2:0] S_MUL1  = 3'd2;
   localparam logic [2:0] S_MUL2  = 3'd3;
   localparam logic [2:0] S_CORR  = 3'd4;
   localparam logic [2:0] S_MUL3  = 3'd5;
   localparam logic [2:0] S_APPLY = 3'd6;

   localparam int CNT_W = $clog2(USEC_W);

   logic [2:0]              state_ff, state_in;
   logic [DIVISOR_W-1:0]    divisor_ff, divisor_in;
   logic                    is_set_ff, is_set_in;
   logic                    sat_ff, sat_in;
   logic [DIVISOR_W-1:0]    rem_ff, rem_in;
   logic [USEC_W-1:0]       quot_ff, quot_in;
   logic [CNT_W-1:0]        step_ff, step_in;
   logic [PROD1_W-1:0]      prod1_ff, prod1_in;
   logic [SEC_STEP_W-1:0]   qest_ff, qest_in;
   logic [USEC_W-1:0]       prod2_ff, prod2_in;
   logic [SEC_STEP_W-1:0]   sec_add_ff, sec_add_in;
   logic [USEC_REM_W-1:0]   rem_us_ff, rem_us_in;
   logic [NSEC_W-1:0]       ns_add_ff, ns_add_in;
   logic [SEC_W-1:0]        clock_sec_ff, clock_sec_in;
   logic [NSEC_W-1:0]       clock_ns_ff, clock_ns_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0]  rsp_data_ff, rsp_data_in;

   logic [DIVISOR_W:0]      trial;
   logic [DIVISOR_W:0]      trial_diff;
   logic                    trial_ge;
   logic [USEC_W-1:0]       corr_diff;
   logic [SEC_W-1:0]        elapsed_hi;
   logic                    out_free;
   logic [SEC_W-1:0]        sec_sum;
   logic [NSEC_W-1:0]       base_ns;
   logic [NSEC_W:0]         ns_sum;
   logic                    ns_carry;
   logic [NSEC_W-1:0]       ns_new;
   logic [SEC_W-1:0]        sec_new;

   assign pop        = (state_ff == S_IDLE) && !queue_status.empty;
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign elapsed_hi = pop_cmd.payload[COUNT_W-1:USEC_W];
   assign trial      = {rem_ff, quot_ff[USEC_W-1]};
   assign trial_diff = trial - {1'b0, divisor_ff};
   assign trial_ge   = (trial >= {1'b0, divisor_ff});
   assign corr_diff  = quot_ff - prod2_ff;

   // Final update: nanoseconds stay below 2e9 before folding, so one carry suffices.
   always_comb begin
      if (is_set_ff) begin
         sec_sum = quot_ff;
         base_ns = '0;
      end else begin
         sec_sum = clock_sec_ff + {{(SEC_W-SEC_STEP_W){1'b0}}, sec_add_ff};
         base_ns = clock_ns_ff;
      end
      ns_sum   = {1'b0, base_ns} + {1'b0, ns_add_ff};
      ns_carry = (ns_sum >= NSEC_PER_SEC);
      ns_new   = ns_carry ? NSEC_W'(ns_sum - NSEC_PER_SEC) : ns_sum[NSEC_W-1:0];
      sec_new  = sec_sum + {{(SEC_W-1){1'b0}}, ns_carry};
   end

   always_comb begin
      state_in     = state_ff;
      divisor_in   = csr_wr_en ? csr_wr_data : divisor_ff;
      is_set_in    = is_set_ff;
      sat_in       = sat_ff;
      rem_in       = rem_ff;
      quot_in      = quot_ff;
      step_in      = step_ff;
      prod1_in     = prod1_ff;
      qest_in      = qest_ff;
      prod2_in     = prod2_ff;
      sec_add_in   = sec_add_ff;
      rem_us_in    = rem_us_ff;
      ns_add_in    = ns_add_ff;
      clock_sec_in = clock_sec_ff;
      clock_ns_in  = clock_ns_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (pop) begin
               is_set_in = pop_cmd.is_set;
               if (pop_cmd.is_set) begin
                  quot_in   = pop_cmd.payload[SEC_W-1:0];
                  ns_add_in = pop_cmd.payload[SEC_W+NSEC_W-1:SEC_W];
                  sat_in    = 1'b0;
                  state_in  = S_APPLY;
               end else if (elapsed_hi >= {{(SEC_W-DIVISOR_W){1'b0}}, divisor_ff}) begin
                  // The quotient needs more than 32 bits; a zero divisor lands here too.
                  quot_in  = '1;
                  sat_in   = 1'b1;
                  state_in = S_MUL1;
               end else begin
                  // The high word is below the divisor, so it is the starting remainder.
                  rem_in   = elapsed_hi[DIVISOR_W-1:0];
                  quot_in  = pop_cmd.payload[USEC_W-1:0];
                  sat_in   = 1'b0;
                  step_in  = '0;
                  state_in = S_DIV;
               end
            end
         end
         S_DIV: begin
            rem_in  = trial_ge ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
            quot_in = {quot_ff[USEC_W-2:0], trial_ge};
            step_in = step_ff + 1'b1;
            if (step_ff == CNT_W'(USEC_W - 1)) begin
               state_in = S_MUL1;
            end
         end
         S_MUL1: begin
            prod1_in = {{RECIP_M_W{1'b0}}, quot_ff[USEC_W-1:RECIP_IN_LSB]}
                     * {{RECIP_IN_W{1'b0}}, RECIP_M};
            state_in = S_MUL2;
         end
         S_MUL2: begin
            qest_in  = prod1_ff[PROD1_W-1:RECIP_SHIFT];
            prod2_in = {{(USEC_W-SEC_STEP_W){1'b0}}, prod1_ff[PROD1_W-1:RECIP_SHIFT]}
                     * USEC_PER_SEC;
            state_in = S_CORR;
         end
         S_CORR: begin
            // The estimate is exact or one low.
            if (corr_diff >= USEC_PER_SEC) begin
               sec_add_in = qest_ff + 1'b1;
               rem_us_in  = USEC_REM_W'(corr_diff - USEC_PER_SEC);
            end else begin
               sec_add_in = qest_ff;
               rem_us_in  = corr_diff[USEC_REM_W-1:0];
            end
            state_in = S_MUL3;
         end
         S_MUL3: begin
            ns_add_in = {{(NSEC_W-USEC_REM_W){1'b0}}, rem_us_ff}
                      * {{(NSEC_W-10){1'b0}}, NSEC_PER_USEC};
            state_in  = S_APPLY;
         end
         S_APPLY: begin
            if (out_free) begin
               clock_sec_in = sec_new;
               clock_ns_in  = ns_new;
               rsp_valid_in = 1'b1;
               rsp_data_in  = {{(RSP_TDATA_W-SEC_W-NSEC_W-1){1'b0}}, sat_ff, ns_new, sec_new};
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         divisor_ff   <= DIVISOR_RESET;
         clock_sec_ff <= '0;
         clock_ns_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         divisor_ff   <= divisor_in;
         clock_sec_ff <= clock_sec_in;
         clock_ns_ff  <= clock_ns_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      is_set_ff   <= is_set_in;
      sat_ff      <= sat_in;
      rem_ff      <= rem_in;
      quot_ff     <= quot_in;
      step_ff     <= step_in;
      prod1_ff    <= prod1_in;
      qest_ff     <= qest_in;
      prod2_ff    <= prod2_in;
      sec_add_ff  <= sec_add_in;
      rem_us_ff   <= rem_us_in;
      ns_add_ff   <= ns_add_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

`default_nettype wire

// ===== hw/rtl/ccwc_checker.sv =====
// Port-level checks of the cycle-count wall clock, bound to the top level.
`default_nettype none

`include "cycle_count_wall_clock_macros.svh"

module ccwc_checker (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tready,
   input  logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   input  logic [ccwc_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   import ccwc_pkg::*;

   // A response that is held back keeps its payload.
   `CCWC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata), "stalled response changed")

   // Nanoseconds are always folded below one second.
   `CCWC_ASSERT_SAME(a_nanos_range, clock, reset, rsp_tvalid,
      {1'b0, rsp_tdata[SEC_W+NSEC_W-1:SEC_W]} < NSEC_PER_SEC,
      "nanoseconds out of range")

   // Reset drops any pending response.
   `CCWC_ASSERT_SAME(a_reset_rsp, clock, 1'b0, $past(reset), !rsp_tvalid,
      "response valid right after reset")

   // Reset leaves the command queue empty, so requests are taken at once.
   `CCWC_ASSERT_SAME(a_reset_ready, clock, 1'b0, $past(reset), req_tready,
      "request not ready right after reset")

endmodule

bind cycle_count_wall_clock ccwc_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire

// ===== sim/tb_top.sv =====
// Self-checking testbench for the cycle-count wall clock, driven through its request stream.
`timescale 1ns / 100ps

module tb_top;
   import ccwc_pkg::*;

   localparam logic [31:0] US_PER_S    = 32'd1000000;
   localparam logic [31:0] NS_PER_US   = 32'd1000;
   localparam logic [31:0] NS_PER_S    = 32'd1000000000;
   localparam int          CYCLE_LIMIT = 500000;
   localparam int          PHASES      = 7;
   localparam int          PHASE_ITEMS = 86;
   localparam int          ROWS        = 20;

   typedef struct packed {
      logic [31:0] seconds;
      logic [29:0] nanos;
      logic        saturated;
   } reading_type;

   typedef struct packed {
      logic        wr_div;   // drain the pipeline and load divisor before this transfer
      logic [15:0] divisor;
      logic        func;
      logic [63:0] counter;
      logic [31:0] set_sec;
      logic [29:0] set_ns;
      logic        known;
      logic [31:0] exp_sec;
      logic [29:0] exp_ns;
      logic        exp_sat;
   } stim_row_type;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   // counter_now[63:0], set_seconds[95:64], set_nanos[125:96], zero pad
   logic [REQ_TDATA_W-1:0] req_tdata;
   // func
   logic                   req_tuser;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   // seconds_now[31:0], nanos_now[61:32], quotient_saturated[62], zero pad
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_wr_en;
   logic [DIVISOR_W-1:0]   csr_wr_data;

   // Predicted state of the clock.
   logic [63:0] wc_prev_count;
   logic [31:0] wc_seconds;
   logic [29:0] wc_nanos;
   logic [15:0] wc_divisor;

   reading_type pending_readings[$];
   int          mismatches = 0;
   int          cycle_count = 0;
   logic        steady_flow = 1'b0;

   stim_row_type directed_rows [ROWS] = '{
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'd0, 32'd0, 30'd0,
        1'b1, 32'd0, 30'd0, 1'b0},
      '{1'b0, 16'd0, FUNC_SET, 64'd0, 32'hFFFF_FFFF, 30'd999999999,
        1'b1, 32'hFFFF_FFFF, 30'd999999999, 1'b0},
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'd1, 32'd0, 30'd0,
        1'b1, 32'd0, 30'd999, 1'b0},
      '{1'b0, 16'd0, FUNC_SET, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF, 30'h3FFF_FFFF,
        1'b1, 32'd0, 30'd73741823, 1'b0},
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'h0000_0001_0000_0001, 32'd0, 30'd0,
        1'b1, 32'd4295, 30'd41036823, 1'b1},
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'd0, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0},
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0},
      '{1'b0, 16'd0, FUNC_SET, 64'd0, 32'd0, 30'd0,
        1'b1, 32'd0, 30'd0, 1'b0},
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 30'd0,
        1'b1, 32'd0, 30'd0, 1'b0},
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'h0000_0000_FFFF_FFFE, 32'd0, 30'd0,
        1'b1, 32'd4294, 30'd967295000, 1'b0},
      '{1'b0, 16'd0, FUNC_SET, 64'd0, 32'h1234_5678, 30'd1000000000,
        1'b1, 32'h1234_5679, 30'd0, 1'b0},
      '{1'b0, 16'd0, FUNC_SET, 64'h5555_5555_5555_5555, 32'hAAAA_5555, 30'h2AAA_AAAA,
        1'b1, 32'hAAAA_5555, 30'h2AAA_AAAA, 1'b0},
      '{1'b0, 16'd0, FUNC_SET, 64'hAAAA_AAAA_AAAA_AAAA, 32'h5555_AAAA, 30'h1555_5555,
        1'b1, 32'h5555_AAAA, 30'h1555_5555, 1'b0},
      '{1'b1, 16'd0, FUNC_SAMPLE, 64'h0000_0001_0000_0000, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0},
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'h0000_0001_0000_0000, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0},
      '{1'b1, 16'hFFFF, FUNC_SAMPLE, 64'h0000_0010_4231_0DC0, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0},
      '{1'b0, 16'd0, FUNC_SAMPLE, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0},
      '{1'b1, 16'h5555, FUNC_SAMPLE, 64'hAAAA_AAAA_AAAA_AAAA, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0},
      '{1'b1, 16'hAAAA, FUNC_SAMPLE, 64'h5555_5555_5555_5555, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0},
      '{1'b1, 16'd1000, FUNC_SAMPLE, 64'h0000_0000_0001_2345, 32'd0, 30'd0,
        1'b0, 32'd0, 30'd0, 1'b0}
   };

   cycle_count_wall_clock uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Updates the predicted clock for one request and returns the time it reports.
   function automatic reading_type advance_wall_clock(input logic func,
                                                      input logic [63:0] counter,
                                                      input logic [31:0] set_sec,
                                                      input logic [29:0] set_ns);
      reading_type reading;
      logic [63:0] elapsed;
      logic [63:0] quot;
      logic [31:0] usec;
      logic [31:0] ns_sum;
      reading.saturated = 1'b0;
      if (func == FUNC_SAMPLE) begin
         elapsed = counter - wc_prev_count;
         wc_prev_count = counter;
         if (wc_divisor == 16'd0) begin
            usec = 32'hFFFF_FFFF;
            reading.saturated = 1'b1;
         end else begin
            quot = elapsed / {48'd0, wc_divisor};
            if (quot > 64'h0000_0000_FFFF_FFFF) begin
               usec = 32'hFFFF_FFFF;
               reading.saturated = 1'b1;
            end else begin
               usec = quot[31:0];
            end
         end
         wc_seconds = wc_seconds + usec / US_PER_S;
         ns_sum = {2'b00, wc_nanos} + (usec % US_PER_S) * NS_PER_US;
      end else begin
         wc_seconds = set_sec;
         ns_sum = {2'b00, set_ns};
      end
      // The sum stays below two seconds, so one carry is enough.
      if (ns_sum >= NS_PER_S) begin
         ns_sum = ns_sum - NS_PER_S;
         wc_seconds = wc_seconds + 32'd1;
      end
      wc_nanos = ns_sum[29:0];
      reading.seconds = wc_seconds;
      reading.nanos = wc_nanos;
      return reading;
   endfunction

   // Holds one request on the bus until its transfer, then records the expected time.
   task automatic send_request(input logic func, input logic [63:0] counter,
                               input logic [31:0] set_sec, input logic [29:0] set_ns,
                               input logic known, input reading_type typed);
      reading_type predicted;
      req_tvalid <= 1'b1;
      req_tuser <= func;
      req_tdata <= {2'b00, set_ns, set_sec, counter};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predicted = advance_wall_clock(func, counter, set_sec, set_ns);
      pending_readings.push_back(known ? typed : predicted);
   endtask

   task automatic sender_gaps();
      while (!steady_flow && $urandom_range(99) < 18) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic drain_pipeline();
      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic program_divisor(input logic [15:0] divisor);
      drain_pipeline();
      csr_wr_en <= 1'b1;
      csr_wr_data <= divisor;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      wc_divisor = divisor;
   endtask

   always @(posedge clock) begin
      rsp_tready <= steady_flow ? 1'b1 : ($urandom_range(99) >= 18);
   end

   always @(posedge clock) begin : rsp_check
      reading_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_readings.size() == 0) begin
            $error("unexpected response transfer: data %h", rsp_tdata);
            mismatches++;
         end else begin
            want = pending_readings.pop_front();
            if (rsp_tdata[31:0] !== want.seconds) begin
               $error("seconds_now: expected %0d, got %0d", want.seconds, rsp_tdata[31:0]);
               mismatches++;
            end
            if (rsp_tdata[61:32] !== want.nanos) begin
               $error("nanos_now: expected %0d, got %0d", want.nanos, rsp_tdata[61:32]);
               mismatches++;
            end
            if (rsp_tdata[62] !== want.saturated) begin
               $error("quotient_saturated: expected %0d, got %0d",
                      want.saturated, rsp_tdata[62]);
               mismatches++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      stim_row_type row;
      reading_type  typed;
      logic [63:0]  count_base;
      logic [63:0]  counter;
      logic [31:0]  set_sec;
      logic [29:0]  set_ns;
      logic [15:0]  divisor;
      int           pick;

      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= FUNC_SAMPLE;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      wc_prev_count = '0;
      wc_seconds = '0;
      wc_nanos = '0;
      wc_divisor = DIVISOR_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (directed_rows[i]) begin
         row = directed_rows[i];
         if (row.wr_div) program_divisor(row.divisor);
         else sender_gaps();
         typed = '{row.exp_sec, row.exp_ns, row.exp_sat};
         send_request(row.func, row.counter, row.set_sec, row.set_ns, row.known, typed);
      end

      count_base = wc_prev_count;
      for (int ph = 0; ph < PHASES; ph++) begin
         case (ph)
            0: divisor = 16'd1;
            1: divisor = 16'hFFFF;
            2: divisor = 16'd0;
            3: divisor = 16'd1000;
            5: divisor = 16'd3000;
            default: divisor = 16'($urandom_range(65535, 1));
         endcase
         program_divisor(divisor);
         // One phase runs with both sides ready on every cycle.
         steady_flow = (ph == 3);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            if (ph == 5 && n == PHASE_ITEMS / 2) drain_pipeline();
            else sender_gaps();
            pick = $urandom_range(99);
            set_sec = $urandom;
            set_ns = ($urandom_range(9) == 0) ? 30'($urandom) : 30'($urandom_range(999999999));
            if (pick < 15) begin
               send_request(FUNC_SET, {$urandom, $urandom}, set_sec, set_ns, 1'b0, '0);
            end else begin
               if (pick < 25) begin
                  counter = {$urandom, $urandom};
               end else begin
                  // Forward steps of widely varying size, most of them short of saturation.
                  counter = count_base + ({$urandom, $urandom} >> $urandom_range(63, 19));
               end
               count_base = counter;
               send_request(FUNC_SAMPLE, counter, set_sec, set_ns, 1'b0, '0);
            end
         end
      end
      steady_flow = 1'b0;

      req_tvalid <= 1'b0;
      while (pending_readings.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
      if (mismatches == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
